// ----- hw/rtl/inpaint_region_labeler_macros.svh -----
// Assertion macros for the inpaint region labeler RTL.
// Included by inpaint_region_labeler, which carries concurrent checks; no other dependencies.
`ifndef INPAINT_REGION_LABELER_MACROS_SVH
`define INPAINT_REGION_LABELER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define IRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/irl_pkg.sv -----
// Shared types and constants of the inpaint region labeler.
// No dependencies; used by irl_cell and inpaint_region_labeler.
package irl_pkg;

    localparam int IRL_MAX_WIDTH  = 1024;
    localparam int IRL_MAX_RADIUS = 8;
    localparam int MAX_HEIGHT     = 4096;

    localparam int FW_W      = 11;   // frame_width register
    localparam int FH_W      = 13;   // frame_height register
    localparam int FR_W      = 4;    // window_radius register
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int IN_ROW_W  = 13;
    localparam int OUT_ROW_W = 12;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [FR_W-1:0] RST_RADIUS       = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [7:0] MISS_RED  = 8'd255;
    localparam logic [7:0] MISS_ZERO = 8'd0;

    localparam logic KIND_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        LBL_BACKGROUND = 3'd0,
        LBL_MISSING    = 3'd1,
        LBL_BORDER     = 3'd2,
        LBL_BAND       = 3'd3,
        LBL_EDGE       = 3'd4
    } t_label;

    // per-column vertical summary, centered d rows above the input row
    typedef struct packed {
        logic center;   // the center row itself is missing
        logic near;     // missing within one row of center
        logic band;     // missing within radius rows of center (0 if radius is 0)
    } t_col_sum;

    // what one chain cell contributes to the current label
    typedef struct packed {
        logic center;
        logic near;
        logic band;
    } t_cell_hit;

    typedef struct packed {
        t_label label;
        logic   last;
    } t_result;

endpackage

// ----- hw/rtl/inpaint_region_labeler.sv -----
// Inpaint region labeler top: counters, column history update, window chain, result queue.
// Depends on irl_pkg, irl_col_mem, irl_cell and inpaint_region_labeler_macros.svh.
// Throughput: one pixel or flush request per cycle while the result queue has room; the chain
//   shifts once per request. A label passes s1, s2, s3 and the result queue after the request that
//   releases it, the request d*W+d positions later in the frame (d = max(radius,1), W = effective width).
// Reset (synchronous, active low) clears counters, stage valids and the 2-entry result queue;
//   the column memory is not cleared, each column restarts its history on row 0.
`include "inpaint_region_labeler_macros.svh"

module inpaint_region_labeler #(
    parameter int MAX_WIDTH  = irl_pkg::IRL_MAX_WIDTH,
    parameter int MAX_RADIUS = irl_pkg::IRL_MAX_RADIUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [irl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irl_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
    input  logic [0:0]                    s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // label[2:0], zero[7:3]
    output logic                          m_axis_tlast   // frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = CW + 1;
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int VW  = 2 * MAX_RADIUS + 1;
    localparam int PW  = WW + 16;
    localparam int DW  = RW + WW + 1;
    localparam int XW  = 16 + RW;
    localparam int IRW = irl_pkg::IN_ROW_W;
    localparam int ORW = irl_pkg::OUT_ROW_W;
    localparam int HW  = irl_pkg::FH_W;

    typedef struct packed {
        logic [CW-1:0] col;
        logic          row_zero;
        logic          miss;
        logic          emit;
        logic          last;
        logic [CW-1:0] ox;
        logic [ORW-1:0] oy;
    } t_stage;

    // configuration
    logic [irl_pkg::FW_W-1:0] r_cfg_width;
    logic [irl_pkg::FH_W-1:0] r_cfg_height;
    logic [irl_pkg::FR_W-1:0] r_cfg_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= irl_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= irl_pkg::RST_FRAME_HEIGHT;
            r_cfg_radius <= irl_pkg::RST_RADIUS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                irl_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[irl_pkg::FW_W-1:0];
                irl_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[irl_pkg::FH_W-1:0];
                irl_pkg::CFG_RADIUS:       r_cfg_radius <= i_cfg_data[irl_pkg::FR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] w_w_eff;
    logic [HW-1:0] w_h_eff;
    logic [RW-1:0] w_r_eff;
    logic [RW-1:0] w_d;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_w_eff = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_w_eff = WW'(MAX_WIDTH);
        end else begin
            w_w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            w_h_eff = HW'(1);
        end else if (32'(r_cfg_height) > irl_pkg::MAX_HEIGHT) begin
            w_h_eff = HW'(irl_pkg::MAX_HEIGHT);
        end else begin
            w_h_eff = r_cfg_height;
        end
        if (32'(r_cfg_radius) > MAX_RADIUS) begin
            w_r_eff = RW'(MAX_RADIUS);
        end else begin
            w_r_eff = RW'(r_cfg_radius);
        end
        w_d = (w_r_eff == '0) ? RW'(1) : w_r_eff;
    end

    // position counters
    logic [CW-1:0]  r_in_col;
    logic [IRW-1:0] r_in_row;
    logic [CW-1:0]  r_out_col;
    logic [ORW-1:0] r_out_row;

    logic                 w_en;
    logic                 w_accept;
    logic                 w_emit;
    logic                 w_last;
    logic                 w_in_frame;
    logic                 w_miss;
    logic signed [IRW:0]  w_row_diff;
    logic signed [CW:0]   w_col_diff;
    logic signed [PW-1:0] w_gap;
    logic [DW-1:0]        w_delay;
    logic                 w_in_col_wrap;
    logic                 w_out_col_wrap;

    assign w_accept = s_axis_tvalid && w_en;
    assign s_axis_tready = w_en;

    assign w_in_frame = (r_in_row < w_h_eff) && ({1'b0, r_in_col} < w_w_eff);
    assign w_miss = w_in_frame && (s_axis_tuser[0] == irl_pkg::KIND_PIXEL)
                  && (s_axis_tdata[7:0] == irl_pkg::MISS_ZERO)
                  && (s_axis_tdata[15:8] == irl_pkg::MISS_ZERO)
                  && (s_axis_tdata[23:16] == irl_pkg::MISS_RED);

    assign w_row_diff = $signed({1'b0, r_in_row}) - $signed({2'b00, r_out_row});
    assign w_col_diff = $signed({1'b0, r_in_col}) - $signed({1'b0, r_out_col});
    assign w_gap      = PW'(w_row_diff) * $signed(PW'(w_w_eff)) + PW'(w_col_diff);
    assign w_delay    = DW'(w_d) * DW'(w_w_eff) + DW'(w_d);
    assign w_emit     = w_gap >= $signed(PW'(w_delay));

    assign w_in_col_wrap  = (WW'(r_in_col) + WW'(1)) >= w_w_eff;
    assign w_out_col_wrap = (WW'(r_out_col) + WW'(1)) >= w_w_eff;
    assign w_last = w_emit && ((HW'(r_out_row) + HW'(1)) >= w_h_eff) && w_out_col_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (w_emit) begin
                    if (w_out_col_wrap) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ORW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
                if (w_in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + IRW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
        end
    end

    // pipeline: s1 reads column history, s2 updates it and feeds the chain, s3 labels
    logic   r_s1_valid, r_s2_valid, r_s3_valid;
    t_stage r_s1, r_s2, r_s3;
    t_stage n_s1;

    always_comb begin
        n_s1.col      = r_in_col;
        n_s1.row_zero = (r_in_row == '0);
        n_s1.miss     = w_miss;
        n_s1.emit     = w_emit;
        n_s1.last     = w_last;
        n_s1.ox       = r_out_col;
        n_s1.oy       = r_out_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // column history: bit k is the missing flag k rows above the input row
    logic          w_wr_en;
    logic [VW-1:0] w_mem_q;
    logic [VW-1:0] w_old;
    logic [VW-1:0] w_new;
    logic          r_lw_en;
    logic [CW-1:0] r_lw_addr;
    logic [VW-1:0] r_lw_data;

    assign w_wr_en = w_en && r_s2_valid;

    irl_col_mem #(
        .DEPTH(MAX_WIDTH),
        .WIDTH(VW)
    ) u_col_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s2.col),
        .i_wr_data (w_new),
        .i_rd_en   (w_en),
        .i_rd_addr (r_s1.col),
        .o_rd_data (w_mem_q)
    );

    // the write at the edge that loaded the read data is not in it yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_en <= 1'b0;
        end else if (w_en) begin
            r_lw_en <= w_wr_en;
        end
        if (w_en) begin
            r_lw_addr <= r_s2.col;
            r_lw_data <= w_new;
        end
    end

    assign w_old = (r_lw_en && (r_lw_addr == r_s2.col)) ? r_lw_data : w_mem_q;
    assign w_new = r_s2.row_zero ? VW'(r_s2.miss) : {w_old[VW-2:0], r_s2.miss};

    irl_pkg::t_col_sum w_sum;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < VW; k++) begin
            if (RW'(k) == w_d && k <= MAX_RADIUS) begin
                w_sum.center = w_sum.center | w_new[k];
            end
            if ((k + 1 >= int'(w_d)) && (k <= int'(w_d) + 1)) begin
                w_sum.near = w_sum.near | w_new[k];
            end
            if ((k <= 2 * int'(w_r_eff)) && (w_r_eff != '0)) begin
                w_sum.band = w_sum.band | w_new[k];
            end
        end
    end

    // horizontal chain, cell j holds the summary of j requests ago
    irl_pkg::t_col_sum  w_chain [VW+1];
    irl_pkg::t_cell_hit w_hit   [VW];

    assign w_chain[0] = w_sum;

    for (genvar j = 0; j < VW; j++) begin : g_cell
        irl_cell #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_RADIUS (MAX_RADIUS),
            .IDX        (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_wr_en),
            .i_sum   (w_chain[j]),
            .o_sum   (w_chain[j+1]),
            .i_ox    (r_s3.ox),
            .i_d     (w_d),
            .i_r     (w_r_eff),
            .i_w     (w_w_eff),
            .o_hit   (w_hit[j])
        );
    end

    logic            w_any_center, w_any_near, w_any_band, w_edge;
    irl_pkg::t_label w_label;

    always_comb begin
        w_any_center = 1'b0;
        w_any_near   = 1'b0;
        w_any_band   = 1'b0;
        for (int j = 0; j < VW; j++) begin
            w_any_center = w_any_center | w_hit[j].center;
            w_any_near   = w_any_near | w_hit[j].near;
            w_any_band   = w_any_band | w_hit[j].band;
        end
    end

    assign w_edge = (XW'(r_s3.ox) < XW'(w_r_eff)) || (XW'(r_s3.oy) < XW'(w_r_eff))
                 || ((XW'(r_s3.ox) + XW'(w_r_eff)) >= XW'(w_w_eff))
                 || ((XW'(r_s3.oy) + XW'(w_r_eff)) >= XW'(w_h_eff));

    always_comb begin
        if (w_any_center) begin
            w_label = irl_pkg::LBL_MISSING;
        end else if (w_any_near) begin
            w_label = irl_pkg::LBL_BORDER;
        end else if (w_any_band) begin
            w_label = irl_pkg::LBL_BAND;
        end else if (w_edge) begin
            w_label = irl_pkg::LBL_EDGE;
        end else begin
            w_label = irl_pkg::LBL_BACKGROUND;
        end
    end

    // two-entry result queue decouples the output handshake from the pipeline
    irl_pkg::t_result r_fifo [2];
    logic             r_rd_ptr, r_wr_ptr;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign w_en   = (r_cnt != 2'd2);
    assign w_push = w_en && r_s3_valid && r_s3.emit;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= '{label: w_label, last: r_s3.last};
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {5'b00000, r_fifo[r_rd_ptr].label};
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

    `IRL_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "result queue overflow")
    `IRL_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_accept && w_last, (r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0) && (r_out_row == '0), "counters not cleared after last label")
    `IRL_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, w_push, m_axis_tvalid, "pushed label not offered")
    `IRL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_s2_valid) && $stable(r_s3_valid), "pipeline moved while stalled")

endmodule

// ----- hw/rtl/irl_col_mem.sv -----
// Column history memory: one word of recent missing flags per column.
// Generic single write port, single registered read port; no dependencies.
module irl_col_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while the pipeline is stalled
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/irl_cell.sv -----
// One cell of the horizontal window chain: holds a column summary, passes it on.
// Depends on irl_pkg for the summary and hit types.
module irl_cell #(
    parameter int MAX_WIDTH  = irl_pkg::IRL_MAX_WIDTH,
    parameter int MAX_RADIUS = irl_pkg::IRL_MAX_RADIUS,
    parameter int IDX        = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_shift,
    input  irl_pkg::t_col_sum                    i_sum,
    output irl_pkg::t_col_sum                    o_sum,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_ox,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]      i_d,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]      i_r,
    input  logic [$clog2(MAX_WIDTH)+1-1:0]       i_w,
    output irl_pkg::t_cell_hit                   o_hit
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int SW = CW + RW + 2;

    irl_pkg::t_col_sum r_sum;

    logic signed [SW-1:0] w_dx;
    logic signed [SW-1:0] w_col;
    logic signed [SW-1:0] w_rs;
    logic signed [SW-1:0] w_one;
    logic                 w_in;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= i_sum;
        end
    end

    // this cell holds column ox + dx of the label's row
    assign w_dx  = $signed(SW'(i_d)) - $signed(SW'(IDX));
    assign w_col = $signed(SW'(i_ox)) + w_dx;
    assign w_rs  = $signed(SW'(i_r));
    assign w_one = $signed(SW'(1));
    assign w_in  = !w_col[SW-1] && (w_col < $signed(SW'(i_w)));

    assign o_hit.center = w_in && (w_dx == '0) && r_sum.center;
    assign o_hit.near   = w_in && (w_dx <= w_one) && (w_dx >= -w_one) && r_sum.near;
    assign o_hit.band   = w_in && (w_dx <= w_rs) && (w_dx >= -w_rs) && r_sum.band;

    assign o_sum = r_sum;

endmodule
